[design/qte_pkg.sv]
// Shared constants, types and functions for the quaternion to Euler angle converter.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package qte_pkg;

  // Width of one rotation matrix term, raw value scaled by 2^28.
  localparam int TW = 35;
  // CORDIC vector width and angle accumulator width (angle unit 2^-30 rad).
  localparam int CW = 38;
  localparam int ZW = 34;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 30;
  localparam int NSTEP = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  // Integer square root of a value up to 2^56: one result bit per stage.
  localparam int SQ_STEPS = 29;
  localparam int SW = 58;
  localparam int RW = 29;
  localparam int UNIT_SHIFT = 28;

  localparam int FIFO_DEPTH = 4;
  localparam int PW = 2;
  localparam int CNTW = 3;

  localparam int RNDW = ZW + 1 - 17;
  localparam int ROLL_LIM = 25736;
  localparam int PITCH_LIM = 12868;

  typedef struct packed {
    logic signed [TW-1:0] m23;
    logic signed [TW-1:0] m33;
    logic signed [TW-1:0] m13;
    logic signed [TW-1:0] m12;
    logic signed [TW-1:0] m11;
  } terms_t;

  // atan(2^-i) scaled by 2^30, rounded to nearest.
  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(843314857);
      1:  v = ZW'(497837829);
      2:  v = ZW'(263043837);
      3:  v = ZW'(133525159);
      4:  v = ZW'(67021687);
      5:  v = ZW'(33543516);
      6:  v = ZW'(16775851);
      7:  v = ZW'(8388437);
      8:  v = ZW'(4194283);
      9:  v = ZW'(2097149);
      10: v = ZW'(1048576);
      11: v = ZW'(524288);
      12: v = ZW'(262144);
      13: v = ZW'(131072);
      14: v = ZW'(65536);
      15: v = ZW'(32768);
      16: v = ZW'(16384);
      17: v = ZW'(8192);
      18: v = ZW'(4096);
      19: v = ZW'(2048);
      20: v = ZW'(1024);
      21: v = ZW'(512);
      22: v = ZW'(256);
      23: v = ZW'(128);
      24: v = ZW'(64);
      25: v = ZW'(32);
      26: v = ZW'(16);
      27: v = ZW'(8);
      28: v = ZW'(4);
      29: v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round an angle in 2^-30 rad to Q3.13 with a floor shift, then clamp to +-lim.
  function automatic logic signed [RNDW-1:0] round_q13(input logic signed [ZW-1:0] z,
                                                       input int lim);
    logic signed [ZW:0] s;
    logic signed [RNDW-1:0] r;
    s = (ZW+1)'(z) + (ZW+1)'(65536);
    r = s[ZW:17];
    if (r > RNDW'(lim)) begin
      r = RNDW'(lim);
    end else if (r < -RNDW'(lim)) begin
      r = -RNDW'(lim);
    end
    return r;
  endfunction

endpackage

[design/qte_front.sv]
// Front end: takes quaternions, forms the pairwise products and the five matrix terms.
// Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_front import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   q_w_i,
  input  logic signed [15:0]   q_x_i,
  input  logic signed [15:0]   q_y_i,
  input  logic signed [15:0]   q_z_i,
  input  logic                 full_i,
  output logic                 push_o,
  output terms_t               push_data_o
);

  logic f1_v_q, f2_v_q, adv;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, yz_q, wx_q, xz_q, wy_q, xy_q, wz_q;
  terms_t terms_d, terms_q;

  // The product stage moves whenever the term stage can pass its item on.
  assign adv = !f2_v_q || !full_i;
  assign in_ready_o = adv;
  assign push_o = f2_v_q && !full_i;
  assign push_data_o = terms_q;

  always_comb begin
    terms_d.m23 = (TW'(yz_q) + TW'(wx_q)) <<< 1;
    terms_d.m33 = TW'(ww_q) - TW'(xx_q) - TW'(yy_q) + TW'(zz_q);
    terms_d.m13 = (TW'(xz_q) - TW'(wy_q)) <<< 1;
    terms_d.m12 = (TW'(xy_q) + TW'(wz_q)) <<< 1;
    terms_d.m11 = TW'(ww_q) + TW'(xx_q) - TW'(yy_q) - TW'(zz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ww_q <= q_w_i * q_w_i;
      xx_q <= q_x_i * q_x_i;
      yy_q <= q_y_i * q_y_i;
      zz_q <= q_z_i * q_z_i;
      yz_q <= q_y_i * q_z_i;
      wx_q <= q_w_i * q_x_i;
      xz_q <= q_x_i * q_z_i;
      wy_q <= q_w_i * q_y_i;
      xy_q <= q_x_i * q_y_i;
      wz_q <= q_w_i * q_z_i;
      terms_q <= terms_d;
    end
  end

endmodule

[design/qte_fifo.sv]
// Short queue of matrix terms between the front end and the angle back end.
// Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_fifo import qte_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  terms_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output terms_t pop_data_o
);

  terms_t mem_q [FIFO_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CNTW-1:0] cnt_q;

  assign full_o = (cnt_q == CNTW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNTW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[design/qte_sqrt.sv]
// Pipelined floor integer square root, one result bit per stage.
// Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_sqrt import qte_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] rad_i,
  output logic [RW-1:0] root_o
);

  logic [SW-1:0] v_q [SQ_STEPS];
  logic [SW-1:0] r_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SW-1:0] v_in, r_in, trial;

    if (k == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_in >= trial) begin
          v_q[k] <= v_in - trial;
          r_q[k] <= (r_in >> 1) + BIT;
        end else begin
          v_q[k] <= v_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQ_STEPS-1][RW-1:0];

endmodule

[design/qte_cordic.sv]
// Pipelined vectoring CORDIC giving atan2(y, x) in units of 2^-30 rad.
// Depends on qte_pkg for widths, step count and the arctangent table.
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] x_i,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] HALF_PI = atan_entry(0) <<< 1;

  logic signed [CW-1:0] x_q [NSTEP+1];
  logic signed [CW-1:0] y_q [NSTEP+1];
  logic signed [ZW-1:0] z_q [NSTEP+1];
  logic                 zero_q [NSTEP+1];

  // Quadrant fold: a vector with negative x is turned by a quarter turn first.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (x_i[CW-1]) begin
        if (!y_i[CW-1]) begin
          x_q[0] <= y_i;
          y_q[0] <= -x_i;
          z_q[0] <= HALF_PI;
        end else begin
          x_q[0] <= -y_i;
          y_q[0] <= x_i;
          z_q[0] <= -HALF_PI;
        end
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = atan_entry(i);
    logic signed [CW-1:0] xs, ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + ANG;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - ANG;
        end
      end
    end
  end

  assign z_o = zero_q[NSTEP] ? '0 : z_q[NSTEP];

endmodule

[design/qte_back.sv]
// Back end: square root of the pitch term, three CORDIC units and the output register.
// Depends on qte_pkg, qte_sqrt and qte_cordic.
`timescale 1ns / 1ps
module qte_back import qte_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  terms_t              pop_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  roll_angle_o,
  output logic signed [14:0]  pitch_angle_o,
  output logic signed [15:0]  yaw_angle_o
);

  localparam int NV = 3 + SQ_STEPS + 1 + NSTEP;
  localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * UNIT_SHIFT);

  logic adv, ov_q;
  logic [NV-1:0] vld_q;
  terms_t t0_q, t1_q, t2_q;
  terms_t td_q [SQ_STEPS];
  logic big1_q, big2_q;
  logic bd_q [SQ_STEPS];
  logic [TW-1:0] am;
  logic [2*UNIT_SHIFT-1:0] sq_q;
  logic [SW-1:0] rad_q;
  logic [RW-1:0] root;
  logic signed [CW-1:0] pitch_x;
  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
  terms_t tl;

  // The whole back end moves as one pipeline whenever the output can take a result.
  assign adv = !ov_q || out_ready_i;
  assign pop_o = adv && !empty_i;
  assign out_valid_o = ov_q;

  assign am = t0_q.m13[TW-1] ? TW'(-t0_q.m13) : TW'(t0_q.m13);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[NV-2:0], pop_o};
      ov_q <= vld_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t0_q <= pop_data_i;
      t1_q <= t0_q;
      big1_q <= (am[TW-1:UNIT_SHIFT] != '0);
      sq_q <= am[UNIT_SHIFT-1:0] * am[UNIT_SHIFT-1:0];
      t2_q <= t1_q;
      big2_q <= big1_q;
      rad_q <= ONE_SQ - SW'(sq_q);
      td_q[0] <= t2_q;
      bd_q[0] <= big2_q;
      for (int k = 1; k < SQ_STEPS; k++) begin
        td_q[k] <= td_q[k-1];
        bd_q[k] <= bd_q[k-1];
      end
    end
  end

  qte_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  assign tl = td_q[SQ_STEPS-1];
  // A pitch term at or beyond unit magnitude leaves no cosine part.
  assign pitch_x = bd_q[SQ_STEPS-1] ? '0 : CW'(root);

  qte_cordic u_roll (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (CW'(tl.m23)),
    .x_i   (CW'(tl.m33)),
    .z_o   (roll_z)
  );

  qte_cordic u_pitch (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (-CW'(tl.m13)),
    .x_i   (pitch_x),
    .z_o   (pitch_z)
  );

  qte_cordic u_yaw (
    .clk_i (clk_i),
    .en_i  (adv),
    .y_i   (CW'(tl.m12)),
    .x_i   (CW'(tl.m11)),
    .z_o   (yaw_z)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_angle_o <= 16'(round_q13(roll_z, ROLL_LIM));
      pitch_angle_o <= 15'(round_q13(pitch_z, PITCH_LIM));
      yaw_angle_o <= 16'(round_q13(yaw_z, ROLL_LIM));
    end
  end

endmodule

[design/quaternion_to_euler_angles_top.sv]
// Quaternion (Q2.14) to ZYX Euler angles (Q3.13 rad, pitch Q2.13 rad): roll, pitch and yaw.
// The path from input transfer to output transfer passes through:
// two product/term stages, the queue, three root setup stages, 29 square root stages,
// a quadrant stage and 16 CORDIC stages, and the output register.
// Throughput is one quaternion per cycle while the output takes results; each stall on the output holds the back end.
// Reset clears only the valid flags, queue pointers and queue count; no clearing pass is needed.
`timescale 1ns / 1ps
module quaternion_to_euler_angles_top import qte_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] q_w_i,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_y_i,
  input  logic signed [15:0] q_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] roll_angle_o,
  output logic signed [14:0] pitch_angle_o,
  output logic signed [15:0] yaw_angle_o
);

  logic push, full, pop, empty;
  terms_t push_data, pop_data;

  qte_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_w_i       (q_w_i),
    .q_x_i       (q_x_i),
    .q_y_i       (q_y_i),
    .q_z_i       (q_z_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  qte_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  qte_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .roll_angle_o  (roll_angle_o),
    .pitch_angle_o (pitch_angle_o),
    .yaw_angle_o   (yaw_angle_o)
  );

endmodule
